@@ rtl/bf2h_pkg.sv @@
// Package for the two-hash Bloom filter: operation codes, fixed field
// widths, and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package bf2h_pkg;

    // Fixed field widths
    localparam int HASH_W    = 64;
    localparam int CFG_W     = 13;
    localparam int DIV_CNT_W = $clog2(HASH_W);

    // Operation codes carried in func
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load;       // latch an accepted item, start remainders
        logic div_step;   // one quotient bit for both hashes
        logic mem_we;     // write a one at the selected position
        logic mem_re;     // read the selected position
        logic sel_b;      // select position b instead of a
        logic cap_a;      // capture the bit read at position a
        logic load_out;   // load the result into the output register
        logic clr_step;   // clear one store entry and advance
    } bf2h_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_last;   // last remainder step in progress
        logic clr_last;   // last store entry being cleared
        logic func;       // operation of the item at work
        logic out_full;   // output register holds an untaken item
    } bf2h_sts_t;

endpackage : bf2h_pkg

`default_nettype wire

@@ rtl/bloom_filter_two_hash.sv @@
// Two-hash Bloom filter over a single-bit store.
// Channels: input items (s_func, s_hash_a, s_hash_b) on s_valid/s_ready,
// one result item (m_maybe_present) per input on m_valid/m_ready, and a
// modulus write channel (cfg_filter_bits_used) on cfg_valid/cfg_ready.
// An add sets the bits at hash_a and hash_b modulo the modulus and
// answers 0; a query answers 1 only when both bits are set.
// Timing: one item at a time. An accepted item is reduced in the
// bit-serial remainder units (one quotient bit per cycle for both hashes
// together), then passes the store port in the access states for position
// a and position b and loads the output register. The next item is taken
// only in the idle state, after the current result has been loaded.
// Reset: the modulus returns to MAX_FILTER_BITS, and a clearing pass
// zeroes all MAX_FILTER_BITS store entries, one entry per cycle, during
// which s_ready stays low; modulus writes are taken at any time.
// Stall: the output register holds an untaken result while the next item
// is accepted and reduced; that item waits in its last step until the
// output register is free.
// Depends on bf2h_pkg, bf2h_ctrl, bf2h_datapath and bf2h_ram.
`default_nettype none

module bloom_filter_two_hash
    import bf2h_pkg::*;
#(
    parameter int MAX_FILTER_BITS = 4096
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_func,
    input  wire logic [HASH_W-1:0] s_hash_a,
    input  wire logic [HASH_W-1:0] s_hash_b,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_maybe_present,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_filter_bits_used
);

    bf2h_cmd_t cmd;
    bf2h_sts_t sts;

    // Modulus writes are always taken
    assign cfg_ready = 1'b1;

    bf2h_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .out_ready (m_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bf2h_datapath #(
        .MAX_FILTER_BITS(MAX_FILTER_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_we            (cfg_valid & cfg_ready),
        .cfg_data          (cfg_filter_bits_used),
        .in_func           (s_func),
        .in_hash_a         (s_hash_a),
        .in_hash_b         (s_hash_b),
        .out_valid         (m_valid),
        .out_ready         (m_ready),
        .out_maybe_present (m_maybe_present)
    );

`ifndef NO_ASSERTIONS
    // One item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is at work");

    // An add always answers zero
    a_add_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out && sts.func == FUNC_ADD) |=> !m_maybe_present)
        else $error("add produced a nonzero result");

    // No input is taken in the cycle after reset: the clearing pass runs
    a_clear_first: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_ready)
        else $error("input accepted before the store was cleared");

    // A result is never loaded over an untaken one
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out && m_valid) |-> m_ready)
        else $error("output register overwritten");
`endif

endmodule : bloom_filter_two_hash

`default_nettype wire

@@ rtl/bf2h_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bf2h_ram #(
    parameter int WIDTH  = 1,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule : bf2h_ram

`default_nettype wire

@@ rtl/bf2h_datapath.sv @@
// Datapath of the two-hash Bloom filter: modulus register, two bit-serial
// remainder units, filter store, clearing counter and output register.
// Depends on bf2h_pkg and bf2h_ram.
`default_nettype none

module bf2h_datapath
    import bf2h_pkg::*;
#(
    parameter int MAX_FILTER_BITS = 4096
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bf2h_cmd_t         cmd,
    output bf2h_sts_t              sts,
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              in_func,
    input  wire logic [HASH_W-1:0] in_hash_a,
    input  wire logic [HASH_W-1:0] in_hash_b,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_maybe_present
);

    localparam int PW = $clog2(MAX_FILTER_BITS);       // bit position width
    localparam int MW = $clog2(MAX_FILTER_BITS + 1);   // modulus width
    localparam int CW = (MW > CFG_W) ? MW : CFG_W;     // config register width

    // One restoring step: shift in a dividend bit, subtract if it fits
    function automatic logic [MW-1:0] rem_step(input logic [MW-1:0] r,
                                               input logic          b,
                                               input logic [MW-1:0] m);
        logic [MW:0] t;
        t = {r, b};
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        return t[MW-1:0];
    endfunction

    logic [CW-1:0]        cfg_reg;
    logic [MW-1:0]        m_eff;
    logic [MW-1:0]        m_reg;
    logic [HASH_W-1:0]    ha_reg, hb_reg;
    logic [MW-1:0]        ra_reg, rb_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 func_reg;
    logic                 bit_a_reg;
    logic [PW-1:0]        clr_cnt_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_bit_reg;
    logic [PW-1:0]        pos;
    logic                 ram_we;
    logic [PW-1:0]        ram_waddr;
    logic                 ram_wdata;
    logic                 ram_rdata;

    // Hold the modulus register; reset to the full store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CW'(MAX_FILTER_BITS);
        end else if (cfg_we) begin
            cfg_reg <= CW'(cfg_data);
        end
    end

    // Clamp the modulus to 1 .. MAX_FILTER_BITS
    always_comb begin
        if (cfg_reg == '0) begin
            m_eff = MW'(1);
        end else if (cfg_reg > CW'(MAX_FILTER_BITS)) begin
            m_eff = MW'(MAX_FILTER_BITS);
        end else begin
            m_eff = cfg_reg[MW-1:0];
        end
    end

    // Latch the item, then advance both remainders one bit per cycle
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_reg    <= m_eff;
            ha_reg   <= in_hash_a;
            hb_reg   <= in_hash_b;
            func_reg <= in_func;
            ra_reg   <= '0;
            rb_reg   <= '0;
        end else if (cmd.div_step) begin
            ra_reg <= rem_step(ra_reg, ha_reg[HASH_W-1], m_reg);
            rb_reg <= rem_step(rb_reg, hb_reg[HASH_W-1], m_reg);
            ha_reg <= {ha_reg[HASH_W-2:0], 1'b0};
            hb_reg <= {hb_reg[HASH_W-2:0], 1'b0};
        end
    end

    // Count remainder steps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.load) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    // Count store entries during the clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_cnt_reg + PW'(1);
        end
    end

    // Remainders stay below the modulus, so they fit a bit position
    assign pos = cmd.sel_b ? rb_reg[PW-1:0] : ra_reg[PW-1:0];

    // Clearing writes zeros, an add writes ones
    assign ram_we    = cmd.mem_we | cmd.clr_step;
    assign ram_waddr = cmd.clr_step ? clr_cnt_reg : pos;
    assign ram_wdata = ~cmd.clr_step;

    bf2h_ram #(
        .WIDTH (1),
        .DEPTH (MAX_FILTER_BITS),
        .ADDR_W(PW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.mem_re),
        .raddr (pos),
        .rdata (ram_rdata)
    );

    // Hold the bit read at position a
    always_ff @(posedge aclk) begin
        if (cmd.cap_a) begin
            bit_a_reg <= ram_rdata;
        end
    end

    // Output register: fill on load, drop when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_bit_reg <= (func_reg == FUNC_QUERY) & bit_a_reg & ram_rdata;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_maybe_present = out_bit_reg;

    // Status toward the controller
    assign sts.div_last = (div_cnt_reg == DIV_CNT_W'(HASH_W - 1));
    assign sts.clr_last = (clr_cnt_reg == PW'(MAX_FILTER_BITS - 1));
    assign sts.func     = func_reg;
    assign sts.out_full = out_valid_reg;

endmodule : bf2h_datapath

`default_nettype wire

@@ rtl/bf2h_ctrl.sv @@
// Controller of the two-hash Bloom filter: sequences clearing, the
// remainder steps, the store accesses and the result hand-off.
// Depends on bf2h_pkg.
`default_nettype none

module bf2h_ctrl
    import bf2h_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire logic      out_ready,
    input  wire bf2h_sts_t sts,
    output bf2h_cmd_t      cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_ACC_A = 3'd3;
    localparam logic [2:0] ST_ACC_B = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       is_add;

    assign is_add = (sts.func == FUNC_ADD);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_ACC_A;
                end
            end
            ST_ACC_A: begin
                cmd.mem_we = is_add;
                cmd.mem_re = ~is_add;
                state_next = ST_ACC_B;
            end
            ST_ACC_B: begin
                cmd.sel_b  = 1'b1;
                cmd.mem_we = is_add;
                cmd.mem_re = ~is_add;
                cmd.cap_a  = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!sts.out_full || out_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule : bf2h_ctrl

`default_nettype wire
